@@ rtl/cla_pkg.sv @@
package cla_pkg;

   // Control characters recognized in the byte stream.
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   // Number of spaces a tab writes when the line has room for all of them.
   localparam int unsigned TAB_WIDTH = 8;

   // Depth of the command queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Width of the line length register.
   localparam int unsigned LEN_W = 7;

   // Command codes produced by the front.
   typedef enum logic [2:0] {
      OP_CHAR      = 3'd0,
      OP_NEWLINE   = 3'd1,
      OP_RETURN    = 3'd2,
      OP_BACKSPACE = 3'd3,
      OP_TAB       = 3'd4
   } op_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } cmd_type;

endpackage

@@ rtl/cla_front.sv @@
module cla_front
   import cla_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   output logic       push_valid,
   output cmd_type    push_cmd,
   input  logic       queue_full
);

   logic    front_valid_ff;
   logic    front_valid_in;
   cmd_type front_cmd_ff;
   cmd_type front_cmd_in;
   logic    accept;
   logic    push;

   // Map the incoming byte onto a command code.
   always_comb begin
      front_cmd_in.ch = req_in_char;
      priority if (req_in_char == CH_NEWLINE) begin
         front_cmd_in.op = OP_NEWLINE;
      end else if (req_in_char == CH_RETURN) begin
         front_cmd_in.op = OP_RETURN;
      end else if (req_in_char == CH_BACKSPACE) begin
         front_cmd_in.op = OP_BACKSPACE;
      end else if (req_in_char == CH_TAB) begin
         front_cmd_in.op = OP_TAB;
      end else begin
         front_cmd_in.op = OP_CHAR;
      end
   end

   // The holding register stalls the input only while the queue is full.
   assign push      = front_valid_ff && !queue_full;
   assign req_stall = front_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_cmd_ff <= front_cmd_in;
      end
   end

   assign push_valid = push;
   assign push_cmd   = front_cmd_ff;

endmodule

@@ rtl/cla_queue.sv @@
module cla_queue
   import cla_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    queue_full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   head_in;
   logic [PTR_W-1:0]   tail_ff;
   logic [PTR_W-1:0]   tail_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_pop;

   assign queue_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[head_ff];
   assign do_pop     = pop && pop_valid;

   // Pointers wrap at the queue depth.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push_valid) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[tail_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/cla_back.sv @@
module cla_back
   import cla_pkg::*;
#(
   parameter int unsigned MAX_LINE = 64
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [LEN_W-1:0] line_length,
   input  logic             pop_valid,
   input  cmd_type          pop_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_line_last,
   output logic             rsp_line_empty
);

   localparam int unsigned POS_W = $clog2(MAX_LINE + 1);
   localparam int unsigned IDX_W = $clog2(MAX_LINE);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_TAB  = 4'b0010,
      ST_READ = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

   back_state_type   state_ff;
   back_state_type   state_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] tab_end_ff;
   logic [POS_W-1:0] tab_end_in;
   logic [POS_W-1:0] len_ff;
   logic [POS_W-1:0] len_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] rd_idx_in;
   logic             empty_ff;
   logic             empty_in;
   logic [7:0]       line_store_ff [MAX_LINE];
   logic [7:0]       store_rdata_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       rsp_char_ff;
   logic             rsp_last_ff;
   logic             rsp_empty_ff;
   logic [POS_W-1:0] limit;
   logic [POS_W:0]   tab_sum;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic             out_free;
   logic             out_load;
   logic             emit_last;

   // Usable length is the register value saturated to the store depth.
   assign limit = (line_length > LEN_W'(MAX_LINE)) ? POS_W'(MAX_LINE)
                                                   : line_length[POS_W-1:0];
   assign tab_sum = {1'b0, pos_ff} + (POS_W + 1)'(TAB_WIDTH);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = empty_ff || ((POS_W'(rd_idx_ff) + POS_W'(1)) == len_ff);
   assign pop       = (state_ff == ST_IDLE) && pop_valid;
   assign rd_en     = (state_ff == ST_READ);
   assign out_load  = (state_ff == ST_EMIT) && out_free;

   // Sequencer: one command at a time; tabs pass through ST_TAB and line drains through ST_READ and ST_EMIT.
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      tab_end_in = tab_end_ff;
      len_in     = len_ff;
      rd_idx_in  = rd_idx_ff;
      empty_in   = empty_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff[IDX_W-1:0];
      wr_data    = CH_SPACE;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_cmd.op)
                  OP_NEWLINE: begin
                     len_in    = pos_ff;
                     rd_idx_in = '0;
                     pos_in    = '0;
                     if (pos_ff == '0) begin
                        empty_in = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        empty_in = 1'b0;
                        state_in = ST_READ;
                     end
                  end
                  OP_RETURN: begin
                     pos_in = '0;
                  end
                  OP_BACKSPACE: begin
                     if (pos_ff != '0) begin
                        pos_in = pos_ff - POS_W'(1);
                     end
                  end
                  OP_TAB: begin
                     if (tab_sum < {1'b0, limit}) begin
                        tab_end_in = tab_sum[POS_W-1:0];
                        state_in   = ST_TAB;
                     end else if (pos_ff < limit) begin
                        tab_end_in = limit;
                        state_in   = ST_TAB;
                     end
                  end
                  OP_CHAR: begin
                     if (pos_ff < limit) begin
                        wr_en   = 1'b1;
                        wr_data = pop_cmd.ch;
                        pos_in  = pos_ff + POS_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TAB: begin
            wr_en  = 1'b1;
            pos_in = pos_ff + POS_W'(1);
            if ((pos_ff + POS_W'(1)) == tab_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_end_ff <= tab_end_in;
      len_ff     <= len_in;
      rd_idx_ff  <= rd_idx_in;
      empty_ff   <= empty_in;
   end

   // Line store with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         store_rdata_ff <= line_store_ff[rd_idx_ff];
      end
   end

   // Output register holds a beat until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_char_ff  <= empty_ff ? 8'd0 : store_rdata_ff;
         rsp_last_ff  <= emit_last;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_line_last  = rsp_last_ff;
   assign rsp_line_empty = rsp_empty_ff;

endmodule

@@ rtl/console_line_assembler.sv @@
// Console line assembler: collects character bytes into a line of up to MAX_LINE
// positions and, on a newline, sends the line out one character per beat with the
// last one marked (an empty line gives a single beat flagged empty, character zero).
// Return, backspace and tab only move the write position; tab fills in spaces, and
// nothing is erased. Input beats pass a holding register and a four-entry command
// queue, so a stalled result side does not stop input until the queue fills. The
// back end handles one command at a time: a printable byte, return or backspace in
// the idle state, a tab's spaces (up to eight) in the tab state, and a newline as
// a store read and an output load per stored character (an empty line: output load
// only), held by output stalls. The user must write the line length register only
// while the block is idle; the block itself has no check for this.
module console_line_assembler
   import cla_pkg::*;
#(
   parameter int unsigned MAX_LINE = 64
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_line_length,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_char,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_line_last,
   output logic             rsp_line_empty
);

   logic [LEN_W-1:0] line_length_ff;
   logic             push_valid;
   cmd_type          push_cmd;
   logic             queue_full;
   logic             pop;
   logic             pop_valid;
   cmd_type          pop_cmd;

   // Line length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LEN_W'(64);
      end else if (csr_wr_en) begin
         line_length_ff <= csr_line_length;
      end
   end

   cla_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full)
   );

   cla_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   cla_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .line_length    (line_length_ff),
      .pop_valid      (pop_valid),
      .pop_cmd        (pop_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_line_last  (rsp_line_last),
      .rsp_line_empty (rsp_line_empty)
   );

endmodule

@@ rtl/cla_checker.sv @@
module cla_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_line_last,
   input logic       rsp_line_empty
);

   // A held result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_line_last) && $stable(rsp_line_empty))
      else $error("stalled result beat changed");

   // An empty line is a single beat that ends the line and carries a zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_empty |-> rsp_line_last && (rsp_out_char == 8'd0))
      else $error("empty line beat malformed");

   // Nothing is offered on the result side right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The input side is open right after reset.
   assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind console_line_assembler cla_checker u_cla_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_char   (rsp_out_char),
   .rsp_line_last  (rsp_line_last),
   .rsp_line_empty (rsp_line_empty)
);
